[sv/shortest_queue_dispatcher_top_defines.svh]
// Assertion macros shared by the dispatcher modules.
// No dependencies; expects aclk and aresetn in the including module.
`ifndef SHORTEST_QUEUE_DISPATCHER_TOP_DEFINES_SVH
`define SHORTEST_QUEUE_DISPATCHER_TOP_DEFINES_SVH

// Clocked property, off while reset is held
`define SQD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be seen out of reset
`define SQD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

[sv/sqd_pkg.sv]
// Shared types and constants for the shortest-queue dispatcher.
// No dependencies; used by sqd_ctrl, sqd_datapath and the top level.
package sqd_pkg;

    localparam int WINDOWS_DEF     = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ARR_W   = 32;
    localparam int SVC_W   = 16;
    localparam int WIN_W   = 4;
    localparam int FIN_W   = 32;
    localparam int CFG_W   = 4;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [CFG_W-1:0] WC_RESET = 4'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // capture request, restart the sweep
        logic load_cur;  // latch window state read data
        logic retire;    // pop head job of current window
        logic wb;        // write current window back, track minimum
        logic next_win;  // advance sweep index
        logic sel_z;     // point index at the chosen window
        logic commit;    // enqueue job and load result register
    } sqd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_zero;   // current window queue empty
        logic head_done;  // head job finished at or before arrival
        logic last_win;   // sweep index at last window
        logic out_free;   // result register can take a new result
    } sqd_stat_t;

endpackage

[sv/shortest_queue_dispatcher_top.sv]
// Shortest-queue dispatcher top level: controller plus datapath.
// Depends on sqd_pkg, sqd_ctrl and sqd_datapath.
//
// Takes one job request (arrival time, service time) at a time, retires every
// queued job finished by the arrival, then places the job on the in-use window
// with the fewest queued jobs (lowest index on a tie; same arrival time as the
// last request reuses that window). The result gives the 1-based window, the
// saturating finish time, and an overflow flag when the chosen FIFO was full.
// For each request the controller visits each window once through the single-port
// window-state memory, and each retirement is one read of the finish store; the
// commit waits for the result register to free up. A result waits in an output
// register, so the next request is taken while it is pending.
// window_count may be written only while no request is in progress.
module shortest_queue_dispatcher_top #(
    parameter int WINDOWS     = sqd_pkg::WINDOWS_DEF,
    parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sqd_pkg::S_TDATA_W-1:0] s_tdata,  // arrival_time[31:0], service_time[47:32]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sqd_pkg::M_TDATA_W-1:0] m_tdata,  // window[3:0], finish_time[35:4], zero pad
    output logic [0:0]                    m_tuser,  // overflow[0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sqd_pkg::CFG_W-1:0]     cfg_data  // window_count
);
    import sqd_pkg::*;

    sqd_cmd_t          cmd;
    sqd_stat_t         stat;
    logic [WIN_W-1:0]  out_window;
    logic [FIN_W-1:0]  out_finish;
    logic              out_overflow;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    sqd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sqd_datapath #(
        .WINDOWS     (WINDOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .out_window   (out_window),
        .out_finish   (out_finish),
        .out_overflow (out_overflow),
        .cmd          (cmd),
        .stat         (stat)
    );

    // Result packing
    assign m_tdata = {{(M_TDATA_W - WIN_W - FIN_W){1'b0}}, out_finish, out_window};
    assign m_tuser = out_overflow;

endmodule

[sv/sqd_ctrl.sv]
// Dispatcher controller: sequences sweep, retire and commit steps.
// Depends on sqd_pkg and shortest_queue_dispatcher_top_defines.svh.
`include "shortest_queue_dispatcher_top_defines.svh"

module sqd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sqd_pkg::sqd_stat_t stat,
    output sqd_pkg::sqd_cmd_t  cmd
);
    import sqd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_W, ST_LD_W, ST_CHK, ST_TST, ST_WB,
        ST_SEL, ST_RD_Z, ST_LD_Z, ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign s_tready = ready_reg;
    assign accept   = s_tvalid && ready_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.start  = 1'b1;
                    ready_next = 1'b0;
                    state_next = ST_RD_W;
                end
            end
            ST_RD_W: state_next = ST_LD_W;
            ST_LD_W: begin
                cmd.load_cur = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK: state_next = stat.cnt_zero ? ST_WB : ST_TST;
            ST_TST: begin
                if (stat.head_done) begin
                    cmd.retire = 1'b1;
                    state_next = ST_CHK;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.wb = 1'b1;
                if (stat.last_win) begin
                    state_next = ST_SEL;
                end else begin
                    cmd.next_win = 1'b1;
                    state_next   = ST_RD_W;
                end
            end
            ST_SEL: begin
                cmd.sel_z  = 1'b1;
                state_next = ST_RD_Z;
            end
            ST_RD_Z: state_next = ST_LD_Z;
            ST_LD_Z: begin
                cmd.load_cur = 1'b1;
                state_next   = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    `SQD_ASSERT_CLK(a_accept_starts_sweep, (s_tvalid && s_tready) |=> (state_reg == ST_RD_W), "accepted request did not start the sweep")
    `SQD_ASSERT_NEVER(a_ready_only_idle, ready_reg != (state_reg == ST_IDLE), "ready out of step with idle state")
    `SQD_ASSERT_CLK(a_last_wb_selects, (state_reg == ST_WB && stat.last_win) |=> (state_reg == ST_SEL), "sweep did not end at last window")

endmodule

[sv/sqd_datapath.sv]
// Dispatcher datapath: per-window queue state, job finish store, result register.
// Depends on sqd_pkg and shortest_queue_dispatcher_top_defines.svh.
`include "shortest_queue_dispatcher_top_defines.svh"

module sqd_datapath #(
    parameter int WINDOWS     = sqd_pkg::WINDOWS_DEF,
    parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sqd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                         cfg_valid,
    input  logic [sqd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [sqd_pkg::WIN_W-1:0]     out_window,
    output logic [sqd_pkg::FIN_W-1:0]     out_finish,
    output logic                         out_overflow,
    input  sqd_pkg::sqd_cmd_t             cmd,
    output sqd_pkg::sqd_stat_t            stat
);
    import sqd_pkg::*;

    localparam int IDX_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH  = WINDOWS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NA_W   = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

    // Per-window state memory (valid bit stands for reset value zero)
    logic [SLOT_W-1:0] head_mem [WINDOWS];
    logic [CNT_W-1:0]  cnt_mem  [WINDOWS];
    logic [FIN_W-1:0]  last_mem [WINDOWS];
    logic [WINDOWS-1:0] win_valid_reg;
    logic [SLOT_W-1:0] rd_head_reg;
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic [FIN_W-1:0]  rd_last_reg;
    logic              rd_valid_reg;

    // Finish-time store, one FIFO region per window
    logic [FIN_W-1:0]  store_mem [DEPTH];
    logic [FIN_W-1:0]  st_rd_reg;

    // Working registers
    logic [ARR_W-1:0]  arr_reg;
    logic [SVC_W-1:0]  dur_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SLOT_W-1:0] cur_head_reg;
    logic [CNT_W-1:0]  cur_cnt_reg;
    logic [FIN_W-1:0]  cur_last_reg;
    logic [CNT_W-1:0]  min_cnt_reg;
    logic [IDX_W-1:0]  min_idx_reg;

    // Previous-arrival record and configuration
    logic [ARR_W-1:0]  prev_arr_reg;
    logic [IDX_W-1:0]  prev_win_reg;
    logic              have_prev_reg;
    logic [CFG_W-1:0]  wc_reg;

    // Result register
    logic              m_valid_reg;
    logic [WIN_W-1:0]  m_win_reg;
    logic [FIN_W-1:0]  m_fin_reg;
    logic              m_ovf_reg;

    logic [NA_W-1:0]   active_n;
    logic [NA_W-1:0]   wc_ext;
    logic              idx_in_use;
    logic              same_ok;
    logic [IDX_W-1:0]  z_sel;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] st_raddr;
    logic [ADDR_W-1:0] st_waddr;
    logic [SLOT_W:0]   head_inc;
    logic [SLOT_W-1:0] head_next;
    logic [SLOT_W:0]   tail_sum;
    logic [SLOT_W-1:0] tail_slot;
    logic              full;
    logic [FIN_W-1:0]  start_t;
    logic [FIN_W:0]    fin_sum;
    logic [FIN_W-1:0]  fin_next;
    logic [WIN_W-1:0]  win_next;

    // Windows in use: zero acts as one, clipped to WINDOWS
    assign wc_ext = NA_W'(wc_reg);
    always_comb begin
        if (wc_reg == '0) begin
            active_n = NA_W'(1);
        end else if (wc_ext > NA_W'(WINDOWS)) begin
            active_n = NA_W'(WINDOWS);
        end else begin
            active_n = wc_ext;
        end
    end

    assign idx_in_use = NA_W'(idx_reg) < active_n;

    // Window choice: repeat previous window on equal arrival time
    assign same_ok = have_prev_reg && (arr_reg == prev_arr_reg) &&
                     (NA_W'(prev_win_reg) < active_n);
    assign z_sel   = same_ok ? prev_win_reg : min_idx_reg;

    // FIFO slot arithmetic
    assign base_addr = ADDR_W'(32'(idx_reg) * QUEUE_DEPTH);
    assign head_inc  = (SLOT_W+1)'(cur_head_reg) + (SLOT_W+1)'(1);
    assign head_next = (head_inc >= (SLOT_W+1)'(QUEUE_DEPTH)) ?
                       SLOT_W'(head_inc - (SLOT_W+1)'(QUEUE_DEPTH)) : SLOT_W'(head_inc);
    assign tail_sum  = (SLOT_W+1)'(cur_head_reg) + (SLOT_W+1)'(cur_cnt_reg);
    assign tail_slot = (tail_sum >= (SLOT_W+1)'(QUEUE_DEPTH)) ?
                       SLOT_W'(tail_sum - (SLOT_W+1)'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
    assign st_raddr  = base_addr + ADDR_W'(cur_head_reg);
    assign st_waddr  = base_addr + ADDR_W'(tail_slot);
    assign full      = (cur_cnt_reg == CNT_W'(QUEUE_DEPTH));

    // Finish time, saturating
    assign start_t  = (cur_last_reg > arr_reg) ? cur_last_reg : arr_reg;
    assign fin_sum  = (FIN_W+1)'(start_t) + (FIN_W+1)'(dur_reg);
    assign fin_next = fin_sum[FIN_W] ? '1 : fin_sum[FIN_W-1:0];
    assign win_next = WIN_W'(32'(idx_reg) + 32'd1);

    // Status
    assign stat.cnt_zero  = (cur_cnt_reg == '0);
    assign stat.head_done = (st_rd_reg <= arr_reg);
    assign stat.last_win  = (idx_reg == IDX_W'(WINDOWS - 1));
    assign stat.out_free  = !m_valid_reg || m_tready;

    // Window state memory: registered read at the index, write on writeback or commit
    always_ff @(posedge aclk) begin
        rd_head_reg  <= head_mem[idx_reg];
        rd_cnt_reg   <= cnt_mem[idx_reg];
        rd_last_reg  <= last_mem[idx_reg];
        if (cmd.wb) begin
            head_mem[idx_reg] <= cur_head_reg;
            cnt_mem[idx_reg]  <= cur_cnt_reg;
            last_mem[idx_reg] <= cur_last_reg;
        end else if (cmd.commit && !full) begin
            head_mem[idx_reg] <= cur_head_reg;
            cnt_mem[idx_reg]  <= cur_cnt_reg + CNT_W'(1);
            last_mem[idx_reg] <= fin_next;
        end
    end

    // Finish store: registered read at the current head
    always_ff @(posedge aclk) begin
        st_rd_reg <= store_mem[st_raddr];
        if (cmd.commit && !full) begin
            store_mem[st_waddr] <= fin_next;
        end
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            prev_arr_reg  <= '0;
            prev_win_reg  <= '0;
            have_prev_reg <= 1'b0;
            wc_reg        <= WC_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= win_valid_reg[idx_reg];
            if (cmd.wb || (cmd.commit && !full)) begin
                win_valid_reg[idx_reg] <= 1'b1;
            end
            if (cfg_valid) begin
                wc_reg <= cfg_data;
            end
            if (cmd.commit) begin
                prev_arr_reg  <= arr_reg;
                prev_win_reg  <= idx_reg;
                have_prev_reg <= 1'b1;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            arr_reg <= s_tdata[ARR_W-1:0];
            dur_reg <= s_tdata[ARR_W+SVC_W-1:ARR_W];
            idx_reg <= '0;
        end
        if (cmd.next_win) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.sel_z) begin
            idx_reg <= z_sel;
        end
        if (cmd.load_cur) begin
            cur_head_reg <= rd_valid_reg ? rd_head_reg : '0;
            cur_cnt_reg  <= rd_valid_reg ? rd_cnt_reg  : '0;
            cur_last_reg <= rd_valid_reg ? rd_last_reg : '0;
        end
        if (cmd.retire) begin
            cur_head_reg <= head_next;
            cur_cnt_reg  <= cur_cnt_reg - CNT_W'(1);
        end
        // shortest queue so far among windows in use, lowest index on tie
        if (cmd.wb && idx_in_use && (idx_reg == '0 || cur_cnt_reg < min_cnt_reg)) begin
            min_cnt_reg <= cur_cnt_reg;
            min_idx_reg <= idx_reg;
        end
        if (cmd.commit) begin
            m_win_reg <= win_next;
            m_fin_reg <= full ? '0 : fin_next;
            m_ovf_reg <= full;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign out_window   = m_win_reg;
    assign out_finish   = m_fin_reg;
    assign out_overflow = m_ovf_reg;

    `SQD_ASSERT_NEVER(a_retire_nonempty, cmd.retire && cur_cnt_reg == '0, "retire from an empty queue")
    `SQD_ASSERT_CLK(a_drop_result, (cmd.commit && full) |=> (m_ovf_reg && m_fin_reg == '0), "dropped job result malformed")
    `SQD_ASSERT_NEVER(a_count_bound, cmd.wb && cur_cnt_reg > CNT_W'(QUEUE_DEPTH), "queue count above depth")

endmodule

[tb/sv/tb_sqd_checker.sv]
`timescale 1ns / 100ps
// Checker for the shortest-queue dispatcher: watches the request, result and
// config channels, predicts each result and compares it. Depends on sqd_pkg.
module tb_sqd_checker #(
    parameter int WINDOWS     = sqd_pkg::WINDOWS_DEF,
    parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sqd_pkg::S_TDATA_W-1:0] s_tdata,  // arrival_time[31:0], service_time[47:32]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sqd_pkg::M_TDATA_W-1:0] m_tdata,  // window[3:0], finish_time[35:4], zero pad
    input  logic [0:0]                    m_tuser,  // overflow[0]
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sqd_pkg::CFG_W-1:0]     cfg_data,  // window_count
    output int                            n_errors,
    output int                            n_pending,
    output int                            n_results,
    output int                            n_overflows,
    output int                            n_saturated
);

    typedef struct packed {
        logic [sqd_pkg::WIN_W-1:0] window;
        logic [sqd_pkg::FIN_W-1:0] finish_time;
        logic                      overflow;
    } dispatch_t;

    // Shadow of the window FIFOs and dispatch history
    logic [31:0]              job_finish [WINDOWS][QUEUE_DEPTH];
    int unsigned              head_idx [WINDOWS];
    int unsigned              job_cnt [WINDOWS];
    logic [31:0]              window_last_fin [WINDOWS];
    logic [31:0]              last_arrival;
    int unsigned              last_window;
    logic                     seen_arrival;
    logic [sqd_pkg::CFG_W-1:0] window_count;

    dispatch_t expected_dispatch_q [$];
    int        err_cnt, result_cnt, ovf_cnt, sat_cnt;

    // Register value clamped to the windows that exist
    function automatic int unsigned windows_in_use();
        if (window_count == 0) return 1;
        if (window_count > WINDOWS) return WINDOWS;
        return int'(window_count);
    endfunction

    // Retire finished jobs, pick the window and enqueue the job
    task automatic predict_dispatch(input logic [31:0] arr, input logic [15:0] svc,
                                    output dispatch_t res);
        int unsigned n, z, slot;
        logic [31:0] start_t;
        logic [32:0] sum;
        for (int w = 0; w < WINDOWS; w++) begin
            while (job_cnt[w] > 0 && job_finish[w][head_idx[w]] <= arr) begin
                head_idx[w] = (head_idx[w] + 1) % QUEUE_DEPTH;
                job_cnt[w]--;
            end
        end
        n = windows_in_use();
        if (seen_arrival && arr == last_arrival && last_window < n) begin
            z = last_window;
        end else begin
            z = 0;
            for (int i = 1; i < n; i++)
                if (job_cnt[i] < job_cnt[z]) z = i;
        end
        res.window = 4'(z + 1);
        if (job_cnt[z] >= QUEUE_DEPTH) begin
            res.finish_time = '0;
            res.overflow    = 1'b1;
        end else begin
            start_t = (window_last_fin[z] > arr) ? window_last_fin[z] : arr;
            sum     = {1'b0, start_t} + {17'd0, svc};
            res.finish_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            res.overflow    = 1'b0;
            slot = (head_idx[z] + job_cnt[z]) % QUEUE_DEPTH;
            job_finish[z][slot] = res.finish_time;
            job_cnt[z]++;
            window_last_fin[z] = res.finish_time;
        end
        last_arrival = arr;
        last_window  = z;
        seen_arrival = 1'b1;
    endtask

    always @(posedge aclk) begin : monitor
        dispatch_t got, want;
        if (!aresetn) begin
            for (int w = 0; w < WINDOWS; w++) begin
                head_idx[w]        = 0;
                job_cnt[w]         = 0;
                window_last_fin[w] = '0;
            end
            last_arrival = '0;
            last_window  = 0;
            seen_arrival = 1'b0;
            window_count = sqd_pkg::WC_RESET;
            expected_dispatch_q.delete();
        end else begin
            // Result side: compare against the oldest expectation
            if (m_tvalid && m_tready) begin
                got.window      = m_tdata[3:0];
                got.finish_time = m_tdata[35:4];
                got.overflow    = m_tuser[0];
                if (expected_dispatch_q.size() == 0) begin
                    $error("unexpected result: window %0d finish_time %0d overflow %0d",
                           got.window, got.finish_time, got.overflow);
                    err_cnt++;
                end else begin
                    want = expected_dispatch_q.pop_front();
                    result_cnt++;
                    if (got.window !== want.window) begin
                        $error("window: expected %0d, actual %0d", want.window, got.window);
                        err_cnt++;
                    end
                    if (got.finish_time !== want.finish_time) begin
                        $error("finish_time: expected %0d, actual %0d",
                               want.finish_time, got.finish_time);
                        err_cnt++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, got.overflow);
                        err_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                window_count = cfg_data;
            // Request side: predict and queue the result
            if (s_tvalid && s_tready) begin
                predict_dispatch(s_tdata[31:0], s_tdata[47:32], want);
                if (want.overflow) ovf_cnt++;
                else if (want.finish_time == 32'hFFFF_FFFF) sat_cnt++;
                expected_dispatch_q.push_back(want);
            end
        end
        n_errors    <= err_cnt;
        n_pending   <= expected_dispatch_q.size();
        n_results   <= result_cnt;
        n_overflows <= ovf_cnt;
        n_saturated <= sat_cnt;
    end

endmodule

[tb/sv/tb_shortest_queue_dispatcher_top.sv]
`timescale 1ns / 100ps
// Testbench top for the shortest-queue dispatcher: clock, reset, request and
// config stimulus, result back-pressure and verdict. Depends on sqd_pkg,
// tb_sqd_checker and shortest_queue_dispatcher_top.
module tb_shortest_queue_dispatcher_top;

    localparam int WINDOWS          = sqd_pkg::WINDOWS_DEF;
    localparam int QUEUE_DEPTH      = sqd_pkg::QUEUE_DEPTH_DEF;
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 20;
    localparam int END_CYCLES       = 100;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int NUM_PHASES       = 7;
    localparam int PHASE_ITEMS      = 190;
    localparam int TIMEOUT_NS       = 15_000_000;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [sqd_pkg::S_TDATA_W-1:0] s_tdata   = '0;  // arrival_time[31:0], service_time[47:32]
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [sqd_pkg::M_TDATA_W-1:0] m_tdata;         // window[3:0], finish_time[35:4], zero pad
    logic [0:0]                    m_tuser;         // overflow[0]
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [sqd_pkg::CFG_W-1:0]     cfg_data  = '0;  // window_count

    int n_errors, n_pending, n_results, n_overflows, n_saturated;
    int n_requests = 0;
    int n_settings = 0;

    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic hold_rx    = 1'b0;

    always #5 aclk = ~aclk;

    shortest_queue_dispatcher_top #(
        .WINDOWS     (WINDOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tb_sqd_checker #(
        .WINDOWS     (WINDOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .n_errors    (n_errors),
        .n_pending   (n_pending),
        .n_results   (n_results),
        .n_overflows (n_overflows),
        .n_saturated (n_saturated)
    );

    // Per-phase knobs: window_count, arrival step and service spread
    function automatic logic [3:0] phase_window_count(input int p);
        case (p)
            0: return 4'd1;
            1: return 4'd8;
            2: return 4'd3;
            3: return 4'd15;
            4: return 4'd0;
            5: return 4'd5;
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic int unsigned phase_step_max(input int p);
        case (p)
            0: return 40;
            1: return 30;
            2: return 200;
            3: return 2000;
            4: return 10;
            5: return 100;
            default: return 300;
        endcase
    endfunction

    function automatic int unsigned phase_svc_max(input int p);
        case (p)
            0: return 300;
            1: return 400;
            2: return 1500;
            3: return 65535;
            4: return 50;
            5: return 700;
            default: return 2500;
        endcase
    endfunction

    // Offer one job request and hold it until accepted
    task automatic send_job(input logic [31:0] arr, input logic [15:0] svc);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {svc, arr};
        do @(posedge aclk); while (!s_tready);
        n_requests++;
    endtask

    // Stop offering and wait until every result is back
    task automatic drain_results(input int extra_cycles);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (extra_cycles) @(posedge aclk);
    endtask

    task automatic write_window_count(input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("shortest_queue_dispatcher_top test failed");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        logic [31:0] cur_t, arr;
        logic [15:0] svc;
        int unsigned step_max, svc_max, sel;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset window_count: fill window 1 at one arrival time until it drops
        send_job(32'd0, 16'd0);
        repeat (17) send_job(32'd10, 16'hFFFF);
        send_job(32'd20, 16'd5);
        send_job(32'd20, 16'd3);

        // Zero acts as one window; previous window now out of range
        drain_results(SETTLE_CYCLES);
        write_window_count(4'd0);
        send_job(32'd20, 16'd7);
        send_job(32'd30, 16'd1);

        // Above the window count acts as all windows; decreasing arrival
        drain_results(SETTLE_CYCLES);
        write_window_count(4'd15);
        send_job(32'd25, 16'd100);
        send_job(32'h0000_1000, 16'h8000);
        send_job(32'h0000_1000, 16'h7FFF);

        // Random phases, each at a fresh time base so old jobs retire
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results(SETTLE_CYCLES);
            tx_idle_on = (p < NUM_PHASES - 1);
            rx_idle_on = (p < NUM_PHASES - 1);
            write_window_count(phase_window_count(p));
            step_max = phase_step_max(p);
            svc_max  = phase_svc_max(p);
            cur_t    = 32'(p + 1) * 32'h2000_0000 + 32'($urandom_range(0, 32'h0FFF_FFFF));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 1 && k == 60) hold_rx = 1'b1;
                sel = $urandom_range(0, 99);
                if (sel < 20) begin
                    arr = cur_t;
                end else if (sel < 25) begin
                    arr = cur_t - 32'($urandom_range(1, 100));
                end else if (sel < 28) begin
                    cur_t = cur_t + 32'($urandom_range(0, 1 << 20));
                    arr   = cur_t;
                end else begin
                    cur_t = cur_t + 32'($urandom_range(0, step_max));
                    arr   = cur_t;
                end
                sel = $urandom_range(0, 99);
                if (sel < 3)      svc = 16'hFFFF;
                else if (sel < 6) svc = 16'd0;
                else              svc = 16'($urandom_range(0, svc_max));
                send_job(arr, svc);
            end
        end

        // Top of the time range: saturating finish times
        drain_results(SETTLE_CYCLES);
        write_window_count(4'd8);
        send_job(32'hFFFF_FF00, 16'hFFFF);
        send_job(32'hFFFF_FF00, 16'd0);
        send_job(32'hFFFF_FFFF, 16'hFFFF);
        send_job(32'hFFFF_FFFF, 16'd0);
        send_job(32'hFFFF_FFFE, 16'd1);

        drain_results(END_CYCLES);
        $display("Sent %0d requests over %0d window_count writes (0 through 15).",
                 n_requests, n_settings);
        $display("Checked %0d results: %0d dropped on a full queue, %0d saturated.",
                 n_results, n_overflows, n_saturated);
        if (n_errors == 0 && n_pending == 0) begin
            $display("shortest_queue_dispatcher_top test passed");
        end else begin
            $display("shortest_queue_dispatcher_top test failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/sqd_pkg.sv
sv/sqd_ctrl.sv
sv/sqd_datapath.sv
sv/shortest_queue_dispatcher_top.sv
tb/sv/tb_sqd_checker.sv
tb/sv/tb_shortest_queue_dispatcher_top.sv
